@@ src/bounded_deque_with_search_core_defines.svh @@
// assertion macros shared by the deque rtl
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// property checked outside reset
`define BDQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold outside reset
`define BDQS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/bdqs_pkg.sv @@
// types and constants of the bounded deque with search
package bdqs_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 6;

  localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 1 + CNT_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_REM_FRONT = 3'd1,
    MODE_REM_BACK  = 3'd2,
    MODE_LIST_FWD  = 3'd3,
    MODE_LIST_BWD  = 3'd4,
    MODE_SEARCH    = 3'd5,
    MODE_COUNT     = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  // shared control for the row of cells
  typedef struct packed {
    logic load;
    logic fwd;
    logic bwd;
  } cell_ctl_t;

endpackage

@@ src/bdqs_cell.sv @@
// one storage cell of the deque chain
module bdqs_cell (
  input  logic                          clk_i,
  input  bdqs_pkg::cell_ctl_t           ctl_i,
  input  logic                          sel_i,
  input  logic [bdqs_pkg::DATA_W-1:0]   load_data_i,
  input  logic [bdqs_pkg::DATA_W-1:0]   next_i,
  input  logic [bdqs_pkg::DATA_W-1:0]   prev_i,
  output logic [bdqs_pkg::DATA_W-1:0]   data_o
);

  logic [bdqs_pkg::DATA_W-1:0] data_q;
  logic [bdqs_pkg::DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load && sel_i) begin
      data_d = load_data_i;
    end else if (ctl_i.fwd) begin
      data_d = next_i;
    end else if (ctl_i.bwd) begin
      data_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ src/bounded_deque_with_search_core.sv @@
// top level of the bounded deque with search, a rotating row of cells
//
//   port group  dir  payload
//   s_axis      in   tdata: value; tuser: mode
//   m_axis      out  tdata: data, found, entry_count; tuser: status; tlast: last
//
// append, remove and count put their result in the output register when the item is accepted
// list and search rotate the whole row once per item, held by output stalls
// the front entry sits in cell 0; a rotation returns the row to its order
// s_axis is held off while a rotation runs or the output register is full and stalled
// reset clears control and counts; cell contents are never cleared
`include "bounded_deque_with_search_core_defines.svh"

module bounded_deque_with_search_core #(
  parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // value [31:0]
  input  logic [bdqs_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // mode [2:0]
  input  logic [bdqs_pkg::MODE_W-1:0]        s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // data [31:0], found [32], entry_count [38:33], zero fill
  output logic [bdqs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status [1:0]
  output logic [bdqs_pkg::STATUS_W-1:0]      m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  localparam int OW = $clog2(DEPTH + 1);
  localparam int KW = $clog2(DEPTH);
  localparam int DW = bdqs_pkg::DATA_W;

  bdqs_pkg::state_e    state_q, state_d;
  bdqs_pkg::mode_e     mode_q, mode_d;
  logic [OW-1:0]       occ_q, occ_d;
  logic [KW-1:0]       k_q, k_d;
  logic [DW-1:0]       key_q, key_d;
  logic                hit_q, hit_d;

  logic                m_valid_q;
  logic [bdqs_pkg::STATUS_W-1:0] m_status_q;
  logic [DW-1:0]       m_data_q;
  logic                m_found_q;
  logic [bdqs_pkg::CNT_W-1:0]    m_cnt_q;
  logic                m_last_q;

  logic                out_load;
  logic [bdqs_pkg::STATUS_W-1:0] out_status;
  logic [DW-1:0]       out_data;
  logic                out_found;
  logic [bdqs_pkg::CNT_W-1:0]    out_cnt;
  logic                out_last;

  bdqs_pkg::cell_ctl_t ctl;
  logic [DW-1:0]       cell_val [DEPTH];

  logic                out_free;
  logic                accept;
  logic                empty;
  logic                full;
  logic                scanning;
  logic                full_append;
  logic [bdqs_pkg::MODE_W-1:0] in_mode;
  logic [DW-1:0]       in_value;
  logic                in_range;
  logic                tail_range;
  logic                at_end;
  logic                match;
  logic                emit;
  logic                step;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == bdqs_pkg::ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign empty           = (occ_q == '0);
  assign full            = (occ_q == OW'(DEPTH));
  assign scanning        = (state_q == bdqs_pkg::ST_SCAN);
  assign full_append     = accept && (in_mode == bdqs_pkg::MODE_APPEND) && full;
  assign in_mode         = s_axis_tuser_i;
  assign in_value        = s_axis_tdata_i[DW-1:0];

  assign in_range   = OW'(k_q) < occ_q;
  assign tail_range = OW'(k_q) >= (OW'(DEPTH) - occ_q);
  assign at_end     = (k_q == KW'(DEPTH - 1));
  assign match      = in_range && (cell_val[0] == key_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    occ_d      = occ_q;
    k_d        = k_q;
    key_d      = key_q;
    hit_d      = hit_q;
    ctl        = '0;
    out_load   = 1'b0;
    out_status = bdqs_pkg::STATUS_OK;
    out_data   = '0;
    out_found  = 1'b0;
    out_cnt    = '0;
    out_last   = 1'b1;
    emit       = 1'b0;
    step       = 1'b0;
    case (state_q)
      bdqs_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            bdqs_pkg::MODE_APPEND: begin
              out_load = 1'b1;
              if (full) begin
                out_status = bdqs_pkg::STATUS_FULL;
              end else begin
                ctl.load = 1'b1;
                occ_d    = occ_q + 1'b1;
              end
            end
            bdqs_pkg::MODE_REM_FRONT, bdqs_pkg::MODE_REM_BACK,
            bdqs_pkg::MODE_LIST_FWD, bdqs_pkg::MODE_LIST_BWD,
            bdqs_pkg::MODE_SEARCH, bdqs_pkg::MODE_COUNT: begin
              if (empty) begin
                out_load   = 1'b1;
                out_status = bdqs_pkg::STATUS_EMPTY;
              end else begin
                case (in_mode)
                  bdqs_pkg::MODE_REM_FRONT: begin
                    out_load = 1'b1;
                    ctl.fwd  = 1'b1;
                    occ_d    = occ_q - 1'b1;
                  end
                  bdqs_pkg::MODE_REM_BACK: begin
                    out_load = 1'b1;
                    occ_d    = occ_q - 1'b1;
                  end
                  bdqs_pkg::MODE_COUNT: begin
                    out_load = 1'b1;
                    out_cnt  = bdqs_pkg::CNT_W'(occ_q);
                  end
                  default: begin
                    state_d = bdqs_pkg::ST_SCAN;
                    mode_d  = bdqs_pkg::mode_e'(in_mode);
                    key_d   = in_value;
                    k_d     = '0;
                    hit_d   = 1'b0;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      bdqs_pkg::ST_SCAN: begin
        case (mode_q)
          bdqs_pkg::MODE_LIST_FWD: begin
            emit     = in_range;
            out_data = cell_val[0];
            out_last = (OW'(k_q) == (occ_q - 1'b1));
          end
          bdqs_pkg::MODE_LIST_BWD: begin
            emit     = tail_range;
            out_data = cell_val[DEPTH-1];
            out_last = at_end;
          end
          default: begin
            emit      = at_end;
            out_found = hit_q || match;
          end
        endcase
        step = !emit || out_free;
        if (step) begin
          out_load = emit;
          ctl.fwd  = (mode_q != bdqs_pkg::MODE_LIST_BWD);
          ctl.bwd  = (mode_q == bdqs_pkg::MODE_LIST_BWD);
          k_d      = k_q + 1'b1;
          hit_d    = hit_q || match;
          if (at_end) begin
            state_d = bdqs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bdqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bdqs_pkg::ST_IDLE;
      occ_q     <= '0;
      k_q       <= '0;
      hit_q     <= 1'b0;
      mode_q    <= bdqs_pkg::MODE_APPEND;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      k_q     <= k_d;
      hit_q   <= hit_d;
      mode_q  <= mode_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_load) begin
      m_status_q <= out_status;
      m_data_q   <= out_data;
      m_found_q  <= out_found;
      m_cnt_q    <= out_cnt;
      m_last_q   <= out_last;
    end
  end

  // row of cells, cell 0 holds the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % DEPTH;
    localparam int PRV = (i + DEPTH - 1) % DEPTH;
    bdqs_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .sel_i       (occ_q == OW'(i)),
      .load_data_i (in_value),
      .next_i      (cell_val[NXT]),
      .prev_i      (cell_val[PRV]),
      .data_o      (cell_val[i])
    );
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = bdqs_pkg::OUT_TDATA_W'({m_cnt_q, m_found_q, m_data_q});

  `BDQS_ASSERT(a_occ_bound, occ_q <= OW'(DEPTH), "occupancy above depth")
  `BDQS_ASSERT(a_scan_keeps_occ, scanning |=> $stable(occ_q), "occupancy moved during scan")
  `BDQS_ASSERT(a_scan_ends, scanning && at_end && step |=> !scanning, "scan did not end")
  `BDQS_ASSERT(a_full_append, full_append |=> $stable(occ_q), "append stored into full deque")
  `BDQS_ASSERT_NEVER(a_no_lost_item, out_load && m_valid_q && !m_axis_tready_i, "result overwritten")

endmodule

@@ sim/tb.sv @@
// self-checking testbench for the bounded deque with search core
module tb;

  localparam int          DEPTH       = bdqs_pkg::DEPTH_DEF;
  localparam int          RAND_ITEMS  = 285;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;

  typedef enum int { PH_FILL, PH_DRAIN, PH_MIX } phase_e;

  typedef struct {
    bdqs_pkg::status_e status;
    logic [31:0]       data;
    logic              found;
    logic [5:0]        entry_count;
    logic              last;
  } deque_result_t;

  class deque_scoreboard;
    logic [31:0]   ring [DEPTH];
    int unsigned   head;
    int unsigned   occupancy;
    deque_result_t expected_q [$];
    int            err_count;

    function void push_result(bdqs_pkg::status_e st, logic [31:0] d, logic f,
                              logic [5:0] c, logic l);
      deque_result_t r;
      r.status      = st;
      r.data        = d;
      r.found       = f;
      r.entry_count = c;
      r.last        = l;
      expected_q.push_back(r);
    endfunction

    function logic [31:0] entry_at(int unsigned offset);
      return ring[(head + offset) % DEPTH];
    endfunction

    function void note_input(logic [2:0] m, logic [31:0] v);
      logic hit;
      if (m == MODE_UNUSED) return;
      if (m == bdqs_pkg::MODE_APPEND) begin
        if (occupancy >= DEPTH) begin
          push_result(bdqs_pkg::STATUS_FULL, '0, 1'b0, '0, 1'b1);
        end else begin
          ring[(head + occupancy) % DEPTH] = v;
          occupancy++;
          push_result(bdqs_pkg::STATUS_OK, '0, 1'b0, '0, 1'b1);
        end
        return;
      end
      if (occupancy == 0) begin
        push_result(bdqs_pkg::STATUS_EMPTY, '0, 1'b0, '0, 1'b1);
        return;
      end
      case (m)
        bdqs_pkg::MODE_REM_FRONT: begin
          head = (head + 1) % DEPTH;
          occupancy--;
          push_result(bdqs_pkg::STATUS_OK, '0, 1'b0, '0, 1'b1);
        end
        bdqs_pkg::MODE_REM_BACK: begin
          occupancy--;
          push_result(bdqs_pkg::STATUS_OK, '0, 1'b0, '0, 1'b1);
        end
        bdqs_pkg::MODE_LIST_FWD: begin
          for (int unsigned i = 0; i < occupancy; i++)
            push_result(bdqs_pkg::STATUS_OK, entry_at(i), 1'b0, '0,
                        i + 1 == occupancy);
        end
        bdqs_pkg::MODE_LIST_BWD: begin
          for (int unsigned i = 0; i < occupancy; i++)
            push_result(bdqs_pkg::STATUS_OK, entry_at(occupancy - 1 - i), 1'b0, '0,
                        i + 1 == occupancy);
        end
        bdqs_pkg::MODE_SEARCH: begin
          hit = 1'b0;
          for (int unsigned i = 0; i < occupancy; i++)
            if (entry_at(i) == v) hit = 1'b1;
          push_result(bdqs_pkg::STATUS_OK, '0, hit, '0, 1'b1);
        end
        default: begin
          push_result(bdqs_pkg::STATUS_OK, '0, 1'b0, occupancy[5:0], 1'b1);
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      err_count++;
    endtask

    task check_result(logic [1:0] st, logic [31:0] d, logic f, logic [5:0] c, logic l);
      deque_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item status %0d data %h last %0d", st, d, l));
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status)
        report($sformatf("status got %0d want %0d", st, e.status));
      if (d !== e.data)
        report($sformatf("data got %h want %h", d, e.data));
      if (f !== e.found)
        report($sformatf("found got %0d want %0d", f, e.found));
      if (c !== e.entry_count)
        report($sformatf("entry_count got %0d want %0d", c, e.entry_count));
      if (l !== e.last)
        report($sformatf("last got %0d want %0d", l, e.last));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [bdqs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [bdqs_pkg::MODE_W-1:0]      s_axis_tuser_i = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [bdqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [bdqs_pkg::STATUS_W-1:0]    m_axis_tuser_o;
  logic                             m_axis_tlast_o;

  deque_scoreboard sb;
  int              burst_left;
  int              cycle_count = 0;
  int              rx_style = 0;

  bounded_deque_with_search_core #(.DEPTH(DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** bounded_deque_with_search_core: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern, restyled at random from four styles
  always @(posedge clk_i) begin
    if (cycle_count % 64 == 0) rx_style <= $urandom_range(0, 3);
    case (rx_style)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready_i <= ($urandom_range(0, 4) != 0);
      default: m_axis_tready_i <= (cycle_count % 4 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tuser_o, m_axis_tdata_o[31:0], m_axis_tdata_o[32],
                      m_axis_tdata_o[38:33], m_axis_tlast_o);
  end

  task automatic send_item(logic [2:0] m, logic [31:0] v);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tuser_i  <= m;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(m, v);
    burst_left--;
  endtask

  task automatic drain_wait();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) return $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    if (sb.occupancy != 0 && $urandom_range(0, 1) == 1)
      return sb.entry_at($urandom_range(0, sb.occupancy - 1));
    return pick_value();
  endfunction

  function automatic logic [2:0] pick_mode(phase_e ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 85) return bdqs_pkg::MODE_APPEND;
        if (r < 89) return bdqs_pkg::MODE_LIST_FWD;
        if (r < 93) return bdqs_pkg::MODE_LIST_BWD;
        if (r < 97) return bdqs_pkg::MODE_SEARCH;
        if (r < 99) return bdqs_pkg::MODE_COUNT;
        return MODE_UNUSED;
      end
      PH_DRAIN: begin
        if (r < 35) return bdqs_pkg::MODE_REM_FRONT;
        if (r < 70) return bdqs_pkg::MODE_REM_BACK;
        if (r < 76) return bdqs_pkg::MODE_LIST_FWD;
        if (r < 82) return bdqs_pkg::MODE_LIST_BWD;
        if (r < 90) return bdqs_pkg::MODE_SEARCH;
        if (r < 95) return bdqs_pkg::MODE_COUNT;
        if (r < 98) return bdqs_pkg::MODE_APPEND;
        return MODE_UNUSED;
      end
      default: begin
        if (r < 30) return bdqs_pkg::MODE_APPEND;
        if (r < 42) return bdqs_pkg::MODE_REM_FRONT;
        if (r < 54) return bdqs_pkg::MODE_REM_BACK;
        if (r < 64) return bdqs_pkg::MODE_LIST_FWD;
        if (r < 74) return bdqs_pkg::MODE_LIST_BWD;
        if (r < 86) return bdqs_pkg::MODE_SEARCH;
        if (r < 96) return bdqs_pkg::MODE_COUNT;
        return MODE_UNUSED;
      end
    endcase
  endfunction

  initial begin
    phase_e      ph;
    int          phase_left;
    int          done;
    logic [2:0]  m;
    sb          = new();
    burst_left  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // requests on an empty store
    send_item(bdqs_pkg::MODE_REM_FRONT, '0);
    send_item(bdqs_pkg::MODE_REM_BACK, '0);
    send_item(bdqs_pkg::MODE_LIST_FWD, '0);
    send_item(bdqs_pkg::MODE_LIST_BWD, '0);
    send_item(bdqs_pkg::MODE_SEARCH, 32'h8000_0000);
    send_item(bdqs_pkg::MODE_COUNT, '0);
    send_item(MODE_UNUSED, 32'hffff_ffff);
    // field extremes
    send_item(bdqs_pkg::MODE_APPEND, 32'h7fff_ffff);
    send_item(bdqs_pkg::MODE_APPEND, 32'h8000_0000);
    send_item(bdqs_pkg::MODE_APPEND, 32'h0000_0000);
    send_item(bdqs_pkg::MODE_APPEND, 32'hffff_ffff);
    send_item(bdqs_pkg::MODE_LIST_FWD, '0);
    send_item(bdqs_pkg::MODE_LIST_BWD, '0);
    send_item(bdqs_pkg::MODE_SEARCH, 32'h8000_0000);
    send_item(bdqs_pkg::MODE_SEARCH, 32'h1234_5678);
    send_item(bdqs_pkg::MODE_COUNT, '0);
    send_item(bdqs_pkg::MODE_REM_FRONT, '0);
    send_item(bdqs_pkg::MODE_REM_BACK, '0);
    send_item(MODE_UNUSED, 32'h5a5a_5a5a);
    send_item(bdqs_pkg::MODE_LIST_FWD, '0);
    send_item(bdqs_pkg::MODE_COUNT, '0);

    // random phases, the first a fill phase of mostly appends that aims to run the store past full
    ph         = PH_FILL;
    phase_left = 45;
    done       = 0;
    while (done < RAND_ITEMS) begin
      if (phase_left == 0) begin
        if ($urandom_range(0, 4) == 0) drain_wait();
        case ($urandom_range(0, 2))
          0: ph = PH_FILL;
          1: ph = PH_DRAIN;
          default: ph = PH_MIX;
        endcase
        phase_left = $urandom_range(15, 45);
      end
      if (done == RAND_ITEMS / 2) drain_wait();
      m = pick_mode(ph);
      send_item(m, (m == bdqs_pkg::MODE_SEARCH) ? pick_key() : pick_value());
      if (m != MODE_UNUSED) done++;
      phase_left--;
    end

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 16) @(posedge clk_i);
    if (sb.err_count == 0) begin
      $display("** bounded_deque_with_search_core: PASSED **");
    end else begin
      $display("** bounded_deque_with_search_core: FAILED **");
    end
    $finish;
  end
endmodule
